@@ rtl/core/tty_canonical_line_editor_assert.svh @@
// assertion macros of the line editor rtl, included by the engine
`ifndef TTY_CANONICAL_LINE_EDITOR_ASSERT_SVH
`define TTY_CANONICAL_LINE_EDITOR_ASSERT_SVH

// condition that holds at every edge out of reset
`define TCE_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
	else $error(msg);

// consequent in the same cycle as the antecedent
`define TCE_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// consequent in the cycle after the antecedent
`define TCE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

@@ rtl/core/tce_pkg.sv @@
// types and constants of the canonical line editor
`timescale 1ns / 1ps
package tce_pkg;

	// buffer geometry
	localparam int BUFFER_DEPTH = 256;
	localparam int PTR_W        = $clog2(BUFFER_DEPTH);
	localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
	localparam int MAX_RESULTS  = 64;
	localparam int READY_MAX    = 511;

	// apb register map
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam logic [2:0] REG_CANONICAL = 3'd0;
	localparam logic [2:0] REG_ERASE     = 3'd1;
	localparam logic [2:0] REG_EOF       = 3'd2;
	localparam logic [2:0] REG_NL_TO_CR  = 3'd3;
	localparam logic [2:0] REG_CR_TO_NL  = 3'd4;
	localparam logic [2:0] REG_FOLD      = 3'd5;

	// register reset values
	localparam logic [7:0] ERASE_RESET = 8'd8;
	localparam logic [7:0] EOF_RESET   = 8'd4;

	// character codes
	localparam logic [7:0] CHAR_LF = 8'h0A;
	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_UA = 8'h41;
	localparam logic [7:0] CHAR_UZ = 8'h5A;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	// operation codes
	localparam logic [1:0] OP_PUSH = 2'd0;
	localparam logic [1:0] OP_READ = 2'd1;
	localparam logic [1:0] OP_POLL = 2'd2;

	// result status codes
	localparam logic [2:0] RS_DATA   = 3'd0;
	localparam logic [2:0] RS_ACCEPT = 3'd1;
	localparam logic [2:0] RS_FULL   = 3'd2;
	localparam logic [2:0] RS_NONE   = 3'd3;
	localparam logic [2:0] RS_EOF    = 3'd4;
	localparam logic [2:0] RS_POLL   = 3'd5;

	typedef struct packed {
		logic       canonical_mode;
		logic [7:0] erase_char;
		logic [7:0] eof_char;
		logic       map_nl_to_cr;
		logic       map_cr_to_nl;
		logic       fold_upper_to_lower;
	} cfg_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] char_in;
		logic [6:0] max_len;
	} cmd_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] data_char;
		logic [8:0] ready_length;
		logic       last;
	} rsp_t;

endpackage

@@ rtl/core/tce_ram.sv @@
// generic single-clock ram, one write port, one registered read port
`timescale 1ns / 1ps
module tce_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/tce_cfg_regs.sv @@
// apb configuration registers of the line editor
`timescale 1ns / 1ps
module tce_cfg_regs
	import tce_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg     = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.canonical_mode      <= 1'b1;
			cfg_q.erase_char          <= ERASE_RESET;
			cfg_q.eof_char            <= EOF_RESET;
			cfg_q.map_nl_to_cr        <= 1'b0;
			cfg_q.map_cr_to_nl        <= 1'b0;
			cfg_q.fold_upper_to_lower <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_CANONICAL: cfg_q.canonical_mode      <= pwdata[0];
				REG_ERASE:     cfg_q.erase_char          <= pwdata[7:0];
				REG_EOF:       cfg_q.eof_char            <= pwdata[7:0];
				REG_NL_TO_CR:  cfg_q.map_nl_to_cr        <= pwdata[0];
				REG_CR_TO_NL:  cfg_q.map_cr_to_nl        <= pwdata[0];
				REG_FOLD:      cfg_q.fold_upper_to_lower <= pwdata[0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (reg_idx)
			REG_CANONICAL: prdata = DATA_W'(cfg_q.canonical_mode);
			REG_ERASE:     prdata = DATA_W'(cfg_q.erase_char);
			REG_EOF:       prdata = DATA_W'(cfg_q.eof_char);
			REG_NL_TO_CR:  prdata = DATA_W'(cfg_q.map_nl_to_cr);
			REG_CR_TO_NL:  prdata = DATA_W'(cfg_q.map_cr_to_nl);
			REG_FOLD:      prdata = DATA_W'(cfg_q.fold_upper_to_lower);
			default:       prdata = '0;
		endcase
	end

endmodule

@@ rtl/core/tce_engine.sv @@
// line buffer engine: push, editing pass and read-out over the buffer ram
`timescale 1ns / 1ps
`include "tty_canonical_line_editor_assert.svh"
module tce_engine
	import tce_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic start,
	output logic busy,
	input  cmd_t cmd,
	output rsp_t rsp,
	output logic rsp_valid
);

	typedef enum logic [1:0] {S_IDLE, S_PASS, S_EMIT} state_t;

	localparam int MIN_W = (CNT_W > 7) ? CNT_W : 7;
	localparam int SAT_W = (CNT_W > 9) ? CNT_W : 9;

	state_t           state_q;
	logic [PTR_W-1:0] head_q, tail_q, rd_ptr_q, wr_ptr_q;
	logic [CNT_W-1:0] count_q, iss_cnt_q, wr_cnt_q, ready_q;
	logic             eof_q, have_end_q, is_poll_q, vld_s1_q;
	logic [6:0]       lim_q, len_q, em_iss_q, em_out_q;
	rsp_t             rsp_q;
	logic             rsp_valid_q;

	logic             accept, full, pass_issue, pass_done, em_issue, em_last;
	logic             active, erase_hit;
	logic [6:0]       lim_sat;
	logic [7:0]       c_out;
	logic             ram_we;
	logic [PTR_W-1:0] ram_waddr;
	logic [7:0]       ram_wdata, ram_rdata;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
		return (p == '0) ? PTR_W'(BUFFER_DEPTH - 1) : p - PTR_W'(1);
	endfunction

	// newline and return mapping, then case folding
	function automatic logic [7:0] translate(input logic [7:0] c, input cfg_t f);
		logic [7:0] m;
		m = c;
		if (f.map_nl_to_cr && c == CHAR_LF) begin
			m = CHAR_CR;
		end else if (f.map_cr_to_nl && c == CHAR_CR) begin
			m = CHAR_LF;
		end
		if (f.fold_upper_to_lower && m >= CHAR_UA && m <= CHAR_UZ) begin
			m = m + CASE_OFFSET;
		end
		return m;
	endfunction

	function automatic logic [6:0] min_len(input logic [CNT_W-1:0] a, input logic [6:0] lim);
		logic [MIN_W-1:0] a_w;
		logic [MIN_W-1:0] l_w;
		a_w = MIN_W'(a);
		l_w = MIN_W'(lim);
		return (a_w < l_w) ? a_w[6:0] : lim;
	endfunction

	function automatic logic [8:0] sat_len(input logic [CNT_W-1:0] v);
		logic [SAT_W-1:0] v_w;
		v_w = SAT_W'(v);
		return (v_w > SAT_W'(READY_MAX)) ? 9'(READY_MAX) : v_w[8:0];
	endfunction

	function automatic rsp_t mk_rsp(input logic [2:0] st, input logic [7:0] ch,
			input logic [8:0] rl, input logic lst);
		rsp_t r;
		r.status       = st;
		r.data_char    = ch;
		r.ready_length = rl;
		r.last         = lst;
		return r;
	endfunction

	// handshake and sequencing terms
	assign busy       = (state_q != S_IDLE);
	assign accept     = start && !busy;
	assign full       = (count_q == CNT_W'(BUFFER_DEPTH));
	assign lim_sat    = (cmd.max_len > 7'(MAX_RESULTS)) ? 7'(MAX_RESULTS) : cmd.max_len;
	assign pass_issue = (iss_cnt_q != count_q);
	assign pass_done  = !pass_issue && !vld_s1_q;
	assign em_issue   = (em_iss_q != len_q);
	assign em_last    = ((em_out_q + 7'd1) == len_q);
	assign rsp        = rsp_q;
	assign rsp_valid  = rsp_valid_q;

	// edit of the byte coming back from the ram
	assign active    = !have_end_q && !eof_q;
	assign erase_hit = active && (wr_cnt_q != '0) && (ram_rdata == cfg.erase_char);
	assign c_out     = active ? translate(ram_rdata, cfg) : ram_rdata;

	// ram write port: push appends, editing pass writes back compacted
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = tail_q;
		ram_wdata = cmd.char_in;
		if (state_q == S_IDLE && accept && cmd.operation == OP_PUSH && !full) begin
			ram_we = 1'b1;
		end else if (state_q == S_PASS && vld_s1_q && !erase_hit) begin
			ram_we    = 1'b1;
			ram_waddr = wr_ptr_q;
			ram_wdata = c_out;
		end
	end

	tce_ram #(
		.WIDTH(8),
		.DEPTH(BUFFER_DEPTH)
	) u_buf (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rd_ptr_q),
		.rdata(ram_rdata)
	);

	// sequencer with registered results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			rd_ptr_q    <= '0;
			wr_ptr_q    <= '0;
			count_q     <= '0;
			iss_cnt_q   <= '0;
			wr_cnt_q    <= '0;
			ready_q     <= '0;
			eof_q       <= 1'b0;
			have_end_q  <= 1'b0;
			is_poll_q   <= 1'b0;
			vld_s1_q    <= 1'b0;
			lim_q       <= '0;
			len_q       <= '0;
			em_iss_q    <= '0;
			em_out_q    <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					vld_s1_q <= 1'b0;
					if (accept) begin
						// set up for an editing pass or a read-out
						rd_ptr_q   <= head_q;
						wr_ptr_q   <= head_q;
						iss_cnt_q  <= '0;
						wr_cnt_q   <= '0;
						have_end_q <= 1'b0;
						ready_q    <= '0;
						lim_q      <= lim_sat;
						em_iss_q   <= '0;
						em_out_q   <= '0;
						is_poll_q  <= (cmd.operation == OP_POLL);
						priority if (cmd.operation == OP_PUSH) begin
							rsp_valid_q <= 1'b1;
							if (full) begin
								rsp_q <= mk_rsp(RS_FULL, 8'd0, 9'd0, 1'b1);
							end else begin
								rsp_q   <= mk_rsp(RS_ACCEPT, 8'd0, 9'd0, 1'b1);
								count_q <= count_q + CNT_W'(1);
								tail_q  <= ptr_inc(tail_q);
							end
						end else if (cmd.operation == OP_POLL) begin
							if (cfg.canonical_mode) begin
								state_q <= S_PASS;
							end else begin
								rsp_q       <= mk_rsp(RS_POLL, 8'd0, sat_len(count_q), 1'b1);
								rsp_valid_q <= 1'b1;
							end
						end else if (cmd.operation != OP_READ || cmd.max_len == '0) begin
							rsp_q       <= mk_rsp(RS_NONE, 8'd0, 9'd0, 1'b1);
							rsp_valid_q <= 1'b1;
						end else if (eof_q) begin
							rsp_q       <= mk_rsp(RS_EOF, 8'd0, 9'd0, 1'b1);
							rsp_valid_q <= 1'b1;
						end else if (cfg.canonical_mode) begin
							state_q <= S_PASS;
						end else if (count_q == '0) begin
							rsp_q       <= mk_rsp(RS_NONE, 8'd0, 9'd0, 1'b1);
							rsp_valid_q <= 1'b1;
						end else begin
							len_q   <= min_len(count_q, lim_sat);
							state_q <= S_EMIT;
						end
					end
				end
				S_PASS: begin
					// read side runs one entry ahead of the write-back
					if (pass_issue) begin
						rd_ptr_q  <= ptr_inc(rd_ptr_q);
						iss_cnt_q <= iss_cnt_q + CNT_W'(1);
					end
					vld_s1_q <= pass_issue;
					if (vld_s1_q) begin
						if (erase_hit) begin
							wr_ptr_q <= ptr_dec(wr_ptr_q);
							wr_cnt_q <= wr_cnt_q - CNT_W'(1);
						end else begin
							wr_ptr_q <= ptr_inc(wr_ptr_q);
							wr_cnt_q <= wr_cnt_q + CNT_W'(1);
							if (active) begin
								if (c_out == CHAR_LF) begin
									have_end_q <= 1'b1;
									ready_q    <= wr_cnt_q + CNT_W'(1);
								end else if (c_out == cfg.eof_char) begin
									have_end_q <= 1'b1;
									ready_q    <= wr_cnt_q;
									eof_q      <= 1'b1;
								end
							end
						end
					end
					// pass finished: commit length and answer or start read-out
					if (pass_done) begin
						count_q <= wr_cnt_q;
						tail_q  <= wr_ptr_q;
						if (is_poll_q) begin
							rsp_q       <= mk_rsp(RS_POLL, 8'd0, sat_len(ready_q), 1'b1);
							rsp_valid_q <= 1'b1;
							state_q     <= S_IDLE;
						end else if (ready_q == '0) begin
							rsp_q       <= mk_rsp(eof_q ? RS_EOF : RS_NONE, 8'd0, 9'd0, 1'b1);
							rsp_valid_q <= 1'b1;
							state_q     <= S_IDLE;
						end else begin
							len_q    <= min_len(ready_q, lim_q);
							rd_ptr_q <= head_q;
							em_iss_q <= '0;
							em_out_q <= '0;
							state_q  <= S_EMIT;
						end
					end
				end
				S_EMIT: begin
					// one data beat per cycle from the head of the buffer
					if (em_issue) begin
						rd_ptr_q <= ptr_inc(rd_ptr_q);
						em_iss_q <= em_iss_q + 7'd1;
					end
					vld_s1_q <= em_issue;
					if (vld_s1_q) begin
						rsp_q       <= mk_rsp(RS_DATA, ram_rdata, 9'd0, em_last);
						rsp_valid_q <= 1'b1;
						head_q      <= ptr_inc(head_q);
						count_q     <= count_q - CNT_W'(1);
						em_out_q    <= em_out_q + 7'd1;
						if (em_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`TCE_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(BUFFER_DEPTH), "fill count beyond depth")
	`TCE_ASSERT_SAME(a_write_behind, state_q == S_PASS, wr_cnt_q <= iss_cnt_q, "write-back overtook read")
	`TCE_ASSERT_NEXT(a_emit_beat, state_q == S_EMIT && vld_s1_q, rsp_valid_q && rsp_q.status == RS_DATA, "read data beat missing")
	`TCE_ASSERT_NEXT(a_push_grows, accept && cmd.operation == OP_PUSH && !full, count_q == $past(count_q) + CNT_W'(1), "push did not grow buffer")
	`TCE_ASSERT_SAME(a_idle_quiet, state_q == S_IDLE, !vld_s1_q, "ram read pending in idle")

endmodule

@@ rtl/core/tty_canonical_line_editor.sv @@
// top level of the canonical terminal line editor
//
//  channel   signals                                   handshake
//  config    psel penable pwrite paddr pwdata prdata   apb, pready always high
//  command   start busy cmd                            taken when start and not busy
//  result    rsp rsp_valid                             one cycle strobe, no back-pressure
//
// a push goes to the buffer directly and its result follows on the next cycle
// a canonical read or poll walks the buffer ram once, through the single read port of
// the buffer; a read then sends out its bytes one by one from the head of the buffer
// a non-canonical read skips the walk; busy is high for the whole walk and read-out
// reset clears counts, pointers and the end-of-file flag; buffer contents are not cleared
// results are strobed once and cannot be held off
`timescale 1ns / 1ps
module tty_canonical_line_editor
	import tce_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              start,
	output logic              busy,
	input  cmd_t              cmd,
	output rsp_t              rsp,
	output logic              rsp_valid
);

	cfg_t cfg;

	// configuration registers
	tce_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	// buffer engine
	tce_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.rsp      (rsp),
		.rsp_valid(rsp_valid)
	);

endmodule

@@ tb/sv/tce_line_checker.sv @@
// line editor checker: follows the config port, predicts each command beat, checks result beats
`timescale 1ns / 1ps
module tce_line_checker
	import tce_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	input  logic              pready,
	input  logic              start,
	input  logic              busy,
	input  cmd_t              cmd,
	input  rsp_t              rsp,
	input  logic              rsp_valid,
	output int                fail_count,
	output int                pending
);

	// own copy of the settings and the line state
	cfg_t       mode;
	logic [7:0] line_mem [BUFFER_DEPTH];
	int         fill_count;
	logic       eof_flag;
	rsp_t       results_due [$];

	function automatic rsp_t result_beat(logic [2:0] st, logic [7:0] ch, logic [8:0] rl,
			logic lst);
		rsp_t r;
		r.status       = st;
		r.data_char    = ch;
		r.ready_length = rl;
		r.last         = lst;
		return r;
	endfunction

	// editing pass over the buffered bytes, compacts them and gives the ready length
	function automatic int edit_line_buffer();
		int         wr;
		int         rd;
		int         ready_len;
		logic       line_done;
		logic [7:0] c;
		wr        = 0;
		ready_len = 0;
		line_done = 1'b0;
		if (!mode.canonical_mode) begin
			return fill_count;
		end
		for (rd = 0; rd < fill_count; rd++) begin
			c = line_mem[rd];
			if (!line_done && !eof_flag) begin
				// erase only bites on a non-empty line, matched on the raw byte
				if (wr != 0 && c == mode.erase_char) begin
					wr--;
					continue;
				end
				if (mode.map_nl_to_cr && c == CHAR_LF)
					c = CHAR_CR;
				else if (mode.map_cr_to_nl && c == CHAR_CR)
					c = CHAR_LF;
				if (mode.fold_upper_to_lower && c >= CHAR_UA && c <= CHAR_UZ)
					c = c + CASE_OFFSET;
				// newline counts in the line, the eof byte does not
				if (c == CHAR_LF) begin
					line_done = 1'b1;
					ready_len = wr + 1;
				end else if (c == mode.eof_char) begin
					line_done = 1'b1;
					ready_len = wr;
					eof_flag  = 1'b1;
				end
			end
			line_mem[wr] = c;
			wr++;
		end
		fill_count = wr;
		return ready_len;
	endfunction

	// expected result beats of one command beat
	function automatic void predict_results(cmd_t c);
		int ready_len;
		int limit;
		int k;
		case (c.operation)
			OP_PUSH: begin
				if (fill_count < BUFFER_DEPTH) begin
					line_mem[fill_count] = c.char_in;
					fill_count++;
					results_due.push_back(result_beat(RS_ACCEPT, 8'd0, 9'd0, 1'b1));
				end else begin
					results_due.push_back(result_beat(RS_FULL, 8'd0, 9'd0, 1'b1));
				end
			end
			OP_POLL: begin
				ready_len = edit_line_buffer();
				if (ready_len > READY_MAX)
					ready_len = READY_MAX;
				results_due.push_back(result_beat(RS_POLL, 8'd0, ready_len[8:0], 1'b1));
			end
			OP_READ: begin
				if (c.max_len == 0) begin
					results_due.push_back(result_beat(RS_NONE, 8'd0, 9'd0, 1'b1));
				end else if (eof_flag) begin
					results_due.push_back(result_beat(RS_EOF, 8'd0, 9'd0, 1'b1));
				end else begin
					ready_len = edit_line_buffer();
					if (ready_len == 0) begin
						results_due.push_back(result_beat(eof_flag ? RS_EOF : RS_NONE,
							8'd0, 9'd0, 1'b1));
					end else begin
						limit = (c.max_len > MAX_RESULTS) ? MAX_RESULTS : int'(c.max_len);
						if (ready_len > limit)
							ready_len = limit;
						if (ready_len > fill_count)
							ready_len = fill_count;
						for (k = 0; k < ready_len; k++)
							results_due.push_back(result_beat(RS_DATA, line_mem[k], 9'd0,
								k == ready_len - 1));
						// shift the remainder down to the head of the buffer
						for (k = 0; k < fill_count - ready_len; k++)
							line_mem[k] = line_mem[k + ready_len];
						fill_count -= ready_len;
					end
				end
			end
			default: begin
				results_due.push_back(result_beat(RS_NONE, 8'd0, 9'd0, 1'b1));
			end
		endcase
	endfunction

	function automatic void write_register(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] value);
		case (addr[ADDR_W-1:2])
			REG_CANONICAL: mode.canonical_mode      = value[0];
			REG_ERASE:     mode.erase_char          = value[7:0];
			REG_EOF:       mode.eof_char            = value[7:0];
			REG_NL_TO_CR:  mode.map_nl_to_cr        = value[0];
			REG_CR_TO_NL:  mode.map_cr_to_nl        = value[0];
			REG_FOLD:      mode.fold_upper_to_lower = value[0];
			default: ;
		endcase
	endfunction

	// compare one result beat with the oldest expectation
	function automatic void check_result(rsp_t seen);
		rsp_t want;
		if (results_due.size() == 0) begin
			fail_count++;
			$display("%0t: unexpected result beat, expected none, actual status %0d data %02h",
				$time, seen.status, seen.data_char, " ready %0d last %0b",
				seen.ready_length, seen.last);
			return;
		end
		want = results_due.pop_front();
		if (seen.status !== want.status || seen.data_char !== want.data_char ||
				seen.ready_length !== want.ready_length || seen.last !== want.last) begin
			fail_count++;
			$display("%0t: result mismatch, expected status %0d data %02h ready %0d last %0b",
				$time, want.status, want.data_char, want.ready_length, want.last);
			$display("%0t: result mismatch, actual   status %0d data %02h ready %0d last %0b",
				$time, seen.status, seen.data_char, seen.ready_length, seen.last);
		end
	endfunction

	// results first: a beat accepted on this edge cannot have answered yet
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode       = '{1'b1, ERASE_RESET, EOF_RESET, 1'b0, 1'b0, 1'b0};
			fill_count = 0;
			eof_flag   = 1'b0;
			results_due.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (psel && penable && pwrite && pready)
				write_register(paddr, pwdata);
			if (rsp_valid)
				check_result(rsp);
			if (start && !busy)
				predict_results(cmd);
			pending = results_due.size();
		end
	end

endmodule

@@ tb/sv/tty_canonical_line_editor_test.sv @@
// testbench top of the canonical line editor: stimulus, pacing and verdict
`timescale 1ns / 1ps
module tty_canonical_line_editor_test;
	import tce_pkg::*;

	// operation code the block does not know
	localparam logic [1:0] OP_UNKNOWN = 2'd3;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              psel      = 1'b0;
	logic              penable   = 1'b0;
	logic              pwrite    = 1'b0;
	logic [ADDR_W-1:0] paddr     = '0;
	logic [DATA_W-1:0] pwdata    = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              start     = 1'b0;
	logic              busy;
	cmd_t              cmd       = '0;
	rsp_t              rsp;
	logic              rsp_valid;
	int                fail_count;
	int                pending;

	// settings as last written, used to keep eof bytes out until the last phase
	cfg_t              line_mode;
	logic              allow_eof  = 1'b0;
	int                burst_left = 0;
	int                sent       = 0;

	tty_canonical_line_editor dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.rsp       (rsp),
		.rsp_valid (rsp_valid)
	);

	tce_line_checker line_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.rsp        (rsp),
		.rsp_valid  (rsp_valid),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #5 clk = ~clk;

	// hard stop well past the slowest correct run
	initial begin
		#10_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic cmd_t make_cmd(logic [1:0] op, logic [7:0] ch, logic [6:0] len);
		cmd_t c;
		c.operation = op;
		c.char_in   = ch;
		c.max_len   = len;
		return c;
	endfunction

	function automatic logic [7:0] translated(logic [7:0] b);
		logic [7:0] t;
		t = b;
		if (line_mode.map_nl_to_cr && t == CHAR_LF)
			t = CHAR_CR;
		else if (line_mode.map_cr_to_nl && t == CHAR_CR)
			t = CHAR_LF;
		if (line_mode.fold_upper_to_lower && t >= CHAR_UA && t <= CHAR_UZ)
			t = t + CASE_OFFSET;
		return t;
	endfunction

	// letters of both cases or any byte; no eof byte unless the last phase allows it
	function automatic logic [7:0] pick_char();
		logic [7:0] b;
		do begin
			case ($urandom_range(0, 2))
				0: b = CHAR_UA + 8'($urandom_range(0, 25));
				1: b = CHAR_UA + CASE_OFFSET + 8'($urandom_range(0, 25));
				default: b = 8'($urandom_range(0, 255));
			endcase
		end while (!allow_eof && (b == line_mode.eof_char ||
				translated(b) == line_mode.eof_char));
		return b;
	endfunction

	function automatic logic [6:0] read_len();
		if ($urandom_range(0, 3) != 0)
			return 7'($urandom_range(1, 64));
		return 7'($urandom_range(0, 127));
	endfunction

	// one command beat, then burst pacing
	task automatic send_beat(cmd_t c);
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
		sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
				: $urandom_range(0, 6);
		end
	endtask

	// apb write: setup cycle then access cycle
	task automatic write_reg(logic [2:0] idx, logic [DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// wait until every expected result has come and the block is quiet
	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		while (busy) @(posedge clk);
		repeat (4) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic apply_mode(cfg_t m);
		write_reg(REG_CANONICAL, DATA_W'(m.canonical_mode));
		write_reg(REG_ERASE, DATA_W'(m.erase_char));
		write_reg(REG_EOF, DATA_W'(m.eof_char));
		write_reg(REG_NL_TO_CR, DATA_W'(m.map_nl_to_cr));
		write_reg(REG_CR_TO_NL, DATA_W'(m.map_cr_to_nl));
		write_reg(REG_FOLD, DATA_W'(m.fold_upper_to_lower));
		line_mode = m;
	endtask

	// empty the buffer with raw reads, then switch to the new settings
	task automatic next_mode(cfg_t m);
		wait_idle();
		write_reg(REG_CANONICAL, '0);
		line_mode.canonical_mode = 1'b0;
		repeat (5) send_beat(make_cmd(OP_READ, pick_char(), 7'd64));
		wait_idle();
		apply_mode(m);
	endtask

	// a line with random content and erases, then sometimes a poll, and a read
	task automatic random_line();
		int n;
		n = $urandom_range(0, 6);
		repeat (n) begin
			if ($urandom_range(0, 5) == 0)
				send_beat(make_cmd(OP_PUSH, line_mode.erase_char,
					7'($urandom_range(0, 127))));
			else
				send_beat(make_cmd(OP_PUSH, pick_char(), 7'($urandom_range(0, 127))));
		end
		if ($urandom_range(0, 5) != 0)
			send_beat(make_cmd(OP_PUSH, $urandom_range(0, 1) ? CHAR_CR : CHAR_LF,
				7'($urandom_range(0, 127))));
		if ($urandom_range(0, 2) == 0)
			send_beat(make_cmd(OP_POLL, pick_char(), 7'($urandom_range(0, 127))));
		send_beat(make_cmd(OP_READ, pick_char(), read_len()));
	endtask

	task automatic random_phase(int count);
		int first;
		first = sent;
		while (sent - first < count) begin
			if ($urandom_range(0, 9) < 7)
				random_line();
			else
				send_beat(make_cmd(2'($urandom_range(0, 3)), pick_char(),
					7'($urandom_range(0, 127))));
		end
	endtask

	initial begin
		cfg_t m;
		line_mode = '{1'b1, ERASE_RESET, EOF_RESET, 1'b0, 1'b0, 1'b0};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty buffer, erase rules, line end, lengths and an unknown operation
		send_beat(make_cmd(OP_READ, 8'h00, 7'd1));
		send_beat(make_cmd(OP_POLL, 8'hFF, 7'd0));
		send_beat(make_cmd(OP_PUSH, ERASE_RESET, 7'd127));
		send_beat(make_cmd(OP_PUSH, CHAR_UA, 7'd0));
		send_beat(make_cmd(OP_PUSH, ERASE_RESET, 7'd0));
		send_beat(make_cmd(OP_PUSH, CHAR_UZ, 7'd0));
		send_beat(make_cmd(OP_PUSH, CHAR_LF, 7'd0));
		send_beat(make_cmd(OP_PUSH, 8'h6D, 7'd0));
		send_beat(make_cmd(OP_POLL, 8'h00, 7'd0));
		send_beat(make_cmd(OP_READ, 8'h00, 7'd0));
		send_beat(make_cmd(OP_READ, 8'h00, 7'd2));
		send_beat(make_cmd(OP_READ, 8'h00, 7'd127));
		send_beat(make_cmd(OP_UNKNOWN, 8'hA5, 7'd64));
		send_beat(make_cmd(OP_PUSH, 8'hFF, 7'd0));
		send_beat(make_cmd(OP_PUSH, 8'h00, 7'd0));
		send_beat(make_cmd(OP_PUSH, 8'h55, 7'd0));
		send_beat(make_cmd(OP_PUSH, CHAR_CR, 7'd0));
		send_beat(make_cmd(OP_PUSH, CHAR_LF, 7'd0));
		send_beat(make_cmd(OP_READ, 8'h00, 7'd1));
		send_beat(make_cmd(OP_READ, 8'h00, 7'd64));
		send_beat(make_cmd(OP_READ, 8'h00, 7'd64));

		// case folding
		m = '{1'b1, 8'h08, 8'h04, 1'b0, 1'b0, 1'b1};
		next_mode(m);
		random_phase(28);

		// carriage return to newline
		m = '{1'b1, 8'h7F, 8'h1A, 1'b0, 1'b1, 1'b0};
		next_mode(m);
		random_phase(28);

		// fill the buffer past full, then look at it
		m = '{1'b1, ERASE_RESET, EOF_RESET, 1'b0, 1'b0, 1'b0};
		next_mode(m);
		repeat (BUFFER_DEPTH + 2) send_beat(make_cmd(OP_PUSH, pick_char(), 7'd0));
		send_beat(make_cmd(OP_POLL, 8'h00, 7'd0));
		send_beat(make_cmd(OP_READ, 8'h00, 7'd64));
		send_beat(make_cmd(OP_READ, 8'h00, 7'd127));

		// both newline maps on with extreme erase and eof bytes
		m = '{1'b1, 8'h00, 8'hFF, 1'b1, 1'b1, 1'b1};
		next_mode(m);
		random_phase(28);

		// raw mode
		m = '{1'b0, 8'hFF, 8'h00, 1'b1, 1'b1, 1'b0};
		next_mode(m);
		random_phase(28);

		m = '{1'b1, 8'h15, EOF_RESET, 1'b0, 1'b0, 1'b0};
		next_mode(m);
		random_phase(24);

		// end of file: set by the pass on an empty line, then sticky
		wait_idle();
		send_beat(make_cmd(OP_PUSH, 8'h71, 7'd0));
		send_beat(make_cmd(OP_PUSH, 8'h15, 7'd0));
		send_beat(make_cmd(OP_PUSH, EOF_RESET, 7'd0));
		send_beat(make_cmd(OP_READ, 8'h00, 7'd64));
		send_beat(make_cmd(OP_READ, 8'h00, 7'd5));
		send_beat(make_cmd(OP_POLL, 8'h00, 7'd0));
		allow_eof = 1'b1;
		random_phase(12);

		wait_idle();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
